/* design/cpbe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cassette pulse burst encoder.
// Used by cpbe_front, cpbe_back and the top level; depends on nothing.
package cpbe_pkg;

  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Input op codes
  typedef enum logic [1:0] {
    OP_LOAD_BYTE    = 2'd0,
    OP_LOAD_SILENCE = 2'd1,
    OP_TICK         = 2'd2,
    OP_NOP          = 2'd3
  } op_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HIGH_LEVEL   = 3'd0,
    REG_LOW_LEVEL    = 3'd1,
    REG_MID_LEVEL    = 3'd2,
    REG_HALF_LEN     = 3'd3,
    REG_GAP_LEN      = 3'd4,
    REG_ZERO_BURST   = 3'd5,
    REG_ONE_BURST    = 3'd6,
    REG_SMOOTH_COEFF = 3'd7
  } reg_idx_t;

  // Command class after the front end
  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_SILENCE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  byte_val;
    logic [15:0] len;
  } cmd_t;

  // Encoder phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PULSE   = 4'b0010,
    PH_GAP     = 4'b0100,
    PH_SILENCE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] high_level;
    logic [7:0] low_level;
    logic [7:0] mid_level;
    logic [7:0] half_len;
    logic [9:0] gap_len;
    logic [3:0] zero_burst;
    logic [3:0] one_burst;
    logic [8:0] smooth_coeff;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    high_level:   8'd250,
    low_level:    8'd0,
    mid_level:    8'd128,
    half_len:     8'd6,
    gap_len:      10'd57,
    zero_burst:   4'd4,
    one_burst:    4'd9,
    smooth_coeff: 9'd218
  };

endpackage

/* design/cpbe_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input items, classifies the op and queues the command.
// Depends on cpbe_pkg.
module cpbe_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_byte_value,
  input  logic [15:0]         in_silence_len,
  output cpbe_pkg::cmd_t      q_cmd,
  output logic                q_valid,
  input  logic                q_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpbe_pkg::cmd_t   slot_r [DEPTH];
  cpbe_pkg::cmd_t   cmd_in;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    cmd_in.byte_val = in_byte_value;
    cmd_in.len      = in_silence_len;
    unique case (in_op)
      cpbe_pkg::OP_LOAD_BYTE:    cmd_in.kind = cpbe_pkg::CMD_BYTE;
      cpbe_pkg::OP_LOAD_SILENCE: cmd_in.kind = cpbe_pkg::CMD_SILENCE;
      cpbe_pkg::OP_TICK:         cmd_in.kind = cpbe_pkg::CMD_TICK;
      cpbe_pkg::OP_NOP:          cmd_in.kind = cpbe_pkg::CMD_NOP;
      default:                   cmd_in.kind = cpbe_pkg::CMD_NOP;
    endcase
  end

  assign in_ready = (count_r != CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count did not shrink on pop");

endmodule

/* design/cpbe_back.sv */
`timescale 1ns / 1ps
// Back end: pulse burst sequencer, first-order smoother and result register.
// Depends on cpbe_pkg.
module cpbe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cpbe_pkg::cfg_t cfg,
  input  cpbe_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_sample,
  output logic           out_sample_valid,
  output logic           out_busy_res,
  output logic           out_load_rejected
);

  typedef struct packed {
    cpbe_pkg::phase_t phase;
    logic [7:0]       shift;
    logic [3:0]       bits;
    logic [3:0]       pulses;
    logic [15:0]      count;
  } seq_t;

  seq_t        seq_r, seq_nxt, act;
  logic [7:0]  level_r;
  logic        out_valid_r;
  logic [7:0]  sample_r;
  logic        sample_valid_r, busy_r, rejected_r;

  logic        fire, tick, rej;
  logic [7:0]  target;
  logic [15:0] cnt_inc;
  logic signed [8:0]  diff;
  logic signed [18:0] prod;
  logic signed [10:0] step;
  logic signed [11:0] sum;
  logic [7:0]  level_new;

  // Skip empty bursts, finished gaps and spent silence so a busy phase always has a
  // sample due. A byte has at most eight bits, so eight passes cover the longest chain.
  function automatic seq_t settle(input seq_t s, input cpbe_pkg::cfg_t c);
    seq_t t;
    t = s;
    for (int k = 0; k < 8; k++) begin
      if (t.phase == cpbe_pkg::PH_PULSE && (c.half_len == '0 || t.pulses == '0)) begin
        t.phase = cpbe_pkg::PH_GAP;
        t.count = '0;
      end
      if (t.phase == cpbe_pkg::PH_GAP && t.count >= {6'd0, c.gap_len}) begin
        t.bits  = t.bits - 4'd1;
        t.shift = {t.shift[6:0], 1'b0};
        t.count = '0;
        if (t.bits == '0) begin
          t.phase = cpbe_pkg::PH_IDLE;
        end else begin
          t.phase  = cpbe_pkg::PH_PULSE;
          t.pulses = t.shift[7] ? c.one_burst : c.zero_burst;
        end
      end
    end
    if (t.phase == cpbe_pkg::PH_SILENCE && t.count == '0) begin
      t.phase = cpbe_pkg::PH_IDLE;
    end
    return t;
  endfunction

  assign cmd_ready = !out_valid_r || out_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign cnt_inc   = seq_r.count + 16'd1;

  always_comb begin
    act    = seq_r;
    target = cfg.mid_level;
    rej    = 1'b0;
    tick   = 1'b0;
    unique case (cmd.kind)
      cpbe_pkg::CMD_BYTE: begin
        if (seq_r.phase != cpbe_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else begin
          act.phase  = cpbe_pkg::PH_PULSE;
          act.shift  = cmd.byte_val;
          act.bits   = cpbe_pkg::BITS_PER_BYTE;
          act.pulses = cmd.byte_val[7] ? cfg.one_burst : cfg.zero_burst;
          act.count  = '0;
        end
      end
      cpbe_pkg::CMD_SILENCE: begin
        if (seq_r.phase != cpbe_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else begin
          act.phase = cpbe_pkg::PH_SILENCE;
          act.count = cmd.len;
        end
      end
      cpbe_pkg::CMD_TICK: begin
        tick = 1'b1;
        unique case (seq_r.phase)
          cpbe_pkg::PH_PULSE: begin
            target = (seq_r.count < {8'd0, cfg.half_len}) ? cfg.high_level
                                                         : cfg.low_level;
            act.count = cnt_inc;
            // End of one pulse: wrap the sample count, drop one pulse
            if (cnt_inc >= {7'd0, cfg.half_len, 1'b0}) begin
              act.count  = '0;
              act.pulses = seq_r.pulses - 4'd1;
            end
          end
          cpbe_pkg::PH_GAP:     act.count = cnt_inc;
          cpbe_pkg::PH_SILENCE: act.count = seq_r.count - 16'd1;
          cpbe_pkg::PH_IDLE:    act.count = seq_r.count;
          default:              act.count = seq_r.count;
        endcase
      end
      cpbe_pkg::CMD_NOP: act = seq_r;
      default:           act = seq_r;
    endcase
    // Hold the state as it is on a no-op or a dropped load; only executed items settle
    if (cmd.kind == cpbe_pkg::CMD_NOP || rej) begin
      seq_nxt = seq_r;
    end else begin
      seq_nxt = settle(act, cfg);
    end
  end

  // Smoother: level + floor((target - level) * coeff / 256), clamped to 0..255
  always_comb begin
    diff = $signed({1'b0, target}) - $signed({1'b0, level_r});
    prod = diff * $signed({1'b0, cfg.smooth_coeff});
    step = prod[18:8];
    sum  = $signed({4'd0, level_r}) + $signed({step[10], step});
    if (sum < 12'sd0) begin
      level_new = 8'd0;
    end else if (sum > 12'sd255) begin
      level_new = 8'd255;
    end else begin
      level_new = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase  <= cpbe_pkg::PH_IDLE;
      seq_r.shift  <= '0;
      seq_r.bits   <= '0;
      seq_r.pulses <= '0;
      seq_r.count  <= '0;
      level_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        seq_r <= seq_nxt;
        if (tick) begin
          level_r <= level_new;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample_r       <= tick ? level_new : 8'd0;
      sample_valid_r <= tick;
      busy_r         <= (seq_nxt.phase != cpbe_pkg::PH_IDLE);
      rejected_r     <= rej;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = sample_r;
  assign out_sample_valid  = sample_valid_r;
  assign out_busy_res      = busy_r;
  assign out_load_rejected = rejected_r;

  a_bits_live: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.phase == cpbe_pkg::PH_PULSE || seq_r.phase == cpbe_pkg::PH_GAP)
      |-> (seq_r.bits != '0 && seq_r.bits <= cpbe_pkg::BITS_PER_BYTE))
    else $error("byte phase with no bits left");

  a_silence_live: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.phase == cpbe_pkg::PH_SILENCE) |-> (seq_r.count != '0))
    else $error("silence phase with nothing left");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rejected_r) |-> (!sample_valid_r && busy_r))
    else $error("rejected load result carries a sample or shows idle");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && tick) |=> (out_valid_r && sample_valid_r && !rejected_r))
    else $error("tick did not produce a sample result");

endmodule

/* design/cassette_pulse_burst_encoder_unit.sv */
`timescale 1ns / 1ps
// Cassette pulse burst encoder: one result per item, one item per clock sustained while
// out_ready stays high. An item is accepted into a short command queue (QUEUE_DEPTH
// entries); the back end takes it from the head of the queue, executes it and loads the
// result register, from which the result is taken. While the output is held off, the
// result register and the queue hold QUEUE_DEPTH + 1 items before in_ready drops.
// The rate is set by the smoother feedback (one 9x10 multiply, add and clamp per cycle
// on the level). Write configuration only while no item is in flight.
// Top level: configuration registers, front end and back end.
// Depends on cpbe_pkg, cpbe_front and cpbe_back.
module cassette_pulse_burst_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [7:0]                        in_byte_value,
  input  logic [15:0]                       in_silence_len,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_sample,
  output logic                              out_sample_valid,
  output logic                              out_busy_res,
  output logic                              out_load_rejected,
  input  logic                              cfg_we,
  input  logic [cpbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cpbe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  cpbe_pkg::cfg_t cfg_r, cfg_nxt;
  cpbe_pkg::cmd_t q_cmd;
  logic           q_valid, q_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cpbe_pkg::REG_HIGH_LEVEL:   cfg_nxt.high_level   = cfg_wdata[7:0];
        cpbe_pkg::REG_LOW_LEVEL:    cfg_nxt.low_level    = cfg_wdata[7:0];
        cpbe_pkg::REG_MID_LEVEL:    cfg_nxt.mid_level    = cfg_wdata[7:0];
        cpbe_pkg::REG_HALF_LEN:     cfg_nxt.half_len     = cfg_wdata[7:0];
        cpbe_pkg::REG_GAP_LEN:      cfg_nxt.gap_len      = cfg_wdata[9:0];
        cpbe_pkg::REG_ZERO_BURST:   cfg_nxt.zero_burst   = cfg_wdata[3:0];
        cpbe_pkg::REG_ONE_BURST:    cfg_nxt.one_burst    = cfg_wdata[3:0];
        cpbe_pkg::REG_SMOOTH_COEFF: cfg_nxt.smooth_coeff = cfg_wdata[8:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cpbe_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cpbe_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_byte_value  (in_byte_value),
    .in_silence_len (in_silence_len),
    .q_cmd          (q_cmd),
    .q_valid        (q_valid),
    .q_ready        (q_ready)
  );

  cpbe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (q_cmd),
    .cmd_valid         (q_valid),
    .cmd_ready         (q_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample),
    .out_sample_valid  (out_sample_valid),
    .out_busy_res      (out_busy_res),
    .out_load_rejected (out_load_rejected)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for cassette_pulse_burst_encoder_unit: directed and random items
// over valid/ready, each result checked against an in-bench pulse burst encoder model.
// Depends on cpbe_pkg and the encoder RTL only.
module tb_top;

  typedef struct packed {
    logic [7:0] sample;
    logic       sample_valid;
    logic       busy;
    logic       rejected;
  } enc_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [1:0]                       in_op;
  logic [7:0]                       in_byte_value;
  logic [15:0]                      in_silence_len;
  logic                             out_valid;
  logic                             out_ready;
  logic [7:0]                       out_sample;
  logic                             out_sample_valid;
  logic                             out_busy_res;
  logic                             out_load_rejected;
  logic                             cfg_we;
  logic [cpbe_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cpbe_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  // Encoder model state
  cpbe_pkg::cfg_t   enc_cfg;
  logic [7:0]       enc_level;
  logic [7:0]       enc_shift;
  logic [3:0]       enc_bits;
  logic [3:0]       enc_pulses;
  cpbe_pkg::phase_t enc_phase;
  logic [15:0]      enc_count;

  enc_result_t predicted_outputs[$];
  int unsigned mismatches;
  bit          idle_on;
  bit          hold_out;

  always #10 clk = ~clk;

  cassette_pulse_burst_encoder_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_byte_value     (in_byte_value),
    .in_silence_len    (in_silence_len),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample),
    .out_sample_valid  (out_sample_valid),
    .out_busy_res      (out_busy_res),
    .out_load_rejected (out_load_rejected),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  function automatic void begin_bit();
    enc_pulses = enc_shift[7] ? enc_cfg.one_burst : enc_cfg.zero_burst;
    enc_phase  = cpbe_pkg::PH_PULSE;
    enc_count  = '0;
  endfunction

  // Skip empty bursts, finished gaps and spent silence so a busy phase has a sample due
  function automatic void skip_empty();
    for (int i = 0; i < 64; i++) begin
      unique case (enc_phase)
        cpbe_pkg::PH_PULSE: begin
          if (enc_cfg.half_len != 0 && enc_pulses != 0) return;
          enc_phase = cpbe_pkg::PH_GAP;
          enc_count = '0;
        end
        cpbe_pkg::PH_GAP: begin
          if (enc_count < enc_cfg.gap_len) return;
          enc_bits  = enc_bits - 4'd1;
          enc_shift = enc_shift << 1;
          if (enc_bits == 0) begin
            enc_phase = cpbe_pkg::PH_IDLE;
            enc_count = '0;
          end else begin
            begin_bit();
          end
        end
        cpbe_pkg::PH_SILENCE: begin
          if (enc_count != 0) return;
          enc_phase = cpbe_pkg::PH_IDLE;
        end
        cpbe_pkg::PH_IDLE: return;
        default: return;
      endcase
    end
  endfunction

  // First-order smoother with floor division and clamp to 0..255
  function automatic logic [7:0] smooth_toward(logic [7:0] target);
    int diff;
    int acc;
    diff = int'(target) - int'(enc_level);
    acc  = int'(enc_level) + ((diff * int'(enc_cfg.smooth_coeff)) >>> 8);
    if (acc < 0) acc = 0;
    else if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  function automatic enc_result_t encode_item(cpbe_pkg::op_t op, logic [7:0] byte_val,
                                              logic [15:0] len);
    enc_result_t res;
    logic [7:0]  target;
    res = '0;
    unique case (op)
      cpbe_pkg::OP_LOAD_BYTE, cpbe_pkg::OP_LOAD_SILENCE: begin
        if (enc_phase != cpbe_pkg::PH_IDLE) begin
          res.rejected = 1'b1;
        end else if (op == cpbe_pkg::OP_LOAD_BYTE) begin
          enc_shift = byte_val;
          enc_bits  = cpbe_pkg::BITS_PER_BYTE;
          begin_bit();
          skip_empty();
        end else begin
          enc_phase = cpbe_pkg::PH_SILENCE;
          enc_count = len;
          skip_empty();
        end
      end
      cpbe_pkg::OP_TICK: begin
        target = enc_cfg.mid_level;
        if (enc_phase == cpbe_pkg::PH_PULSE) begin
          target    = (enc_count < enc_cfg.half_len) ? enc_cfg.high_level
                                                     : enc_cfg.low_level;
          enc_count = enc_count + 16'd1;
          if (enc_count >= {enc_cfg.half_len, 1'b0}) begin
            enc_count  = '0;
            enc_pulses = enc_pulses - 4'd1;
          end
        end else if (enc_phase == cpbe_pkg::PH_GAP) begin
          enc_count = enc_count + 16'd1;
        end else if (enc_phase == cpbe_pkg::PH_SILENCE) begin
          enc_count = enc_count - 16'd1;
        end
        skip_empty();
        enc_level        = smooth_toward(target);
        res.sample       = enc_level;
        res.sample_valid = 1'b1;
      end
      cpbe_pkg::OP_NOP: ;
      default: ;
    endcase
    res.busy = (enc_phase != cpbe_pkg::PH_IDLE);
    return res;
  endfunction

  task automatic send_item(cpbe_pkg::op_t op, logic [7:0] byte_val, logic [15:0] len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_byte_value  <= byte_val;
    in_silence_len <= len;
    do @(posedge clk); while (!in_ready);
    predicted_outputs.push_back(encode_item(op, byte_val, len));
  endtask

  task automatic send_tick();
    send_item(cpbe_pkg::OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic tick_until_quiet();
    while (enc_phase != cpbe_pkg::PH_IDLE) send_tick();
  endtask

  // Drop valid and wait out every pending result before touching registers
  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cpbe_pkg::reg_idx_t idx, logic [cpbe_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    unique case (idx)
      cpbe_pkg::REG_HIGH_LEVEL:   enc_cfg.high_level   = value[7:0];
      cpbe_pkg::REG_LOW_LEVEL:    enc_cfg.low_level    = value[7:0];
      cpbe_pkg::REG_MID_LEVEL:    enc_cfg.mid_level    = value[7:0];
      cpbe_pkg::REG_HALF_LEN:     enc_cfg.half_len     = value[7:0];
      cpbe_pkg::REG_GAP_LEN:      enc_cfg.gap_len      = value;
      cpbe_pkg::REG_ZERO_BURST:   enc_cfg.zero_burst   = value[3:0];
      cpbe_pkg::REG_ONE_BURST:    enc_cfg.one_burst    = value[3:0];
      cpbe_pkg::REG_SMOOTH_COEFF: enc_cfg.smooth_coeff = value[8:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(logic [9:0] half, logic [9:0] gap, logic [9:0] zero,
                             logic [9:0] one);
    write_reg(cpbe_pkg::REG_HALF_LEN, half);
    write_reg(cpbe_pkg::REG_GAP_LEN, gap);
    write_reg(cpbe_pkg::REG_ZERO_BURST, zero);
    write_reg(cpbe_pkg::REG_ONE_BURST, one);
  endtask

  task automatic load_levels(logic [9:0] high, logic [9:0] low, logic [9:0] mid,
                             logic [9:0] coeff);
    write_reg(cpbe_pkg::REG_HIGH_LEVEL, high);
    write_reg(cpbe_pkg::REG_LOW_LEVEL, low);
    write_reg(cpbe_pkg::REG_MID_LEVEL, mid);
    write_reg(cpbe_pkg::REG_SMOOTH_COEFF, coeff);
  endtask

  // Reset config: idle ticks ramp the level from zero toward mid
  task automatic test_idle_ticks();
    send_tick();
    send_tick();
    send_item(cpbe_pkg::OP_NOP, 8'hFF, 16'hFFFF);
    send_tick();
  endtask

  task automatic test_silence_runs();
    send_item(cpbe_pkg::OP_LOAD_SILENCE, 8'h00, 16'd0);
    send_tick();
    send_item(cpbe_pkg::OP_LOAD_SILENCE, 8'h00, 16'd3);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h5A, 16'd0);
    send_item(cpbe_pkg::OP_LOAD_SILENCE, 8'h00, 16'd7);
    send_item(cpbe_pkg::OP_NOP, 8'h00, 16'd0);
    tick_until_quiet();
    send_tick();
  endtask

  task automatic test_byte_patterns();
    drain_results();
    load_timing(10'd1, 10'd0, 10'd1, 10'd2);
    load_levels(10'd250, 10'd0, 10'd128, 10'd256);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h00, 16'd0);
    tick_until_quiet();
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'hFF, 16'd0);
    send_tick();
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h11, 16'd0);
    tick_until_quiet();
  endtask

  task automatic test_empty_bursts();
    drain_results();
    // zero half length: the whole byte collapses at load
    load_timing(10'd0, 10'd0, 10'd4, 10'd9);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'hC3, 16'd0);
    send_tick();
    drain_results();
    // zero pulse counts: gaps only
    load_timing(10'd2, 10'd3, 10'd0, 10'd0);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h81, 16'd0);
    tick_until_quiet();
    drain_results();
    load_timing(10'd2, 10'd0, 10'd1, 10'd3);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h96, 16'd0);
    tick_until_quiet();
  endtask

  task automatic test_level_extremes();
    drain_results();
    load_timing(10'd2, 10'd1, 10'd1, 10'd2);
    load_levels(10'd255, 10'd0, 10'd255, 10'd0);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'hF0, 16'd0);
    tick_until_quiet();
    drain_results();
    // gain above unity overshoots and must clamp at both rails
    load_levels(10'd255, 10'd0, 10'd0, 10'h3FF);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h3C, 16'd0);
    tick_until_quiet();
    drain_results();
    load_levels(10'h300, 10'h3FF, 10'h255, 10'd218);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'hA5, 16'd0);
    tick_until_quiet();
  endtask

  task automatic test_long_extremes();
    idle_on = 1'b0;
    drain_results();
    // upper bits above each register width are dropped
    load_timing(10'h302, 10'd5, 10'h3F1, 10'h3F2);
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h80, 16'd0);
    tick_until_quiet();
    send_item(cpbe_pkg::OP_LOAD_SILENCE, 8'h00, 16'd150);
    tick_until_quiet();
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    drain_results();
    load_timing(10'd1, 10'd2, 10'd2, 10'd3);
    hold_out = 1'b1;
    send_item(cpbe_pkg::OP_LOAD_BYTE, 8'h5A, 16'd0);
    repeat (60) send_tick();
    tick_until_quiet();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    for (int round = 0; round < 5; round++) begin
      drain_results();
      idle_on = (round < 4);
      load_timing(($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 3)),
                  10'($urandom_range(0, 6)), 10'($urandom_range(0, 4)),
                  10'($urandom_range(0, 4)));
      load_levels(10'($urandom_range(0, 255)), 10'($urandom_range(0, 255)),
                  10'($urandom_range(0, 255)),
                  ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 511))
                                              : 10'($urandom_range(128, 256)));
      repeat (220) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)
          send_item(cpbe_pkg::OP_LOAD_BYTE, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
        else if (pick < 14)
          send_item(cpbe_pkg::OP_LOAD_SILENCE, 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1000))
                                                : 16'($urandom_range(0, 20)));
        else if (pick < 17)
          send_item(cpbe_pkg::OP_NOP, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
        else
          send_tick();
      end
    end
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    enc_result_t got;
    enc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_sample, out_sample_valid, out_busy_res, out_load_rejected};
      if (predicted_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: %p", $time, got);
      end else begin
        want = predicted_outputs.pop_front();
        if (got.sample !== want.sample || got.sample_valid !== want.sample_valid ||
            got.busy !== want.busy || got.rejected !== want.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: sample %0d/%0d valid %0b/%0b busy %0b/%0b",
                      " rejected %0b/%0b (exp/act)"},
                     $time, want.sample, got.sample, want.sample_valid, got.sample_valid,
                     want.busy, got.busy, want.rejected, got.rejected);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned waited;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = cpbe_pkg::OP_NOP;
    in_byte_value  = '0;
    in_silence_len = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    idle_on        = 1'b1;
    hold_out       = 1'b0;
    mismatches     = 0;
    enc_cfg        = cpbe_pkg::CFG_RESET;
    enc_level      = '0;
    enc_shift      = '0;
    enc_bits       = '0;
    enc_pulses     = '0;
    enc_phase      = cpbe_pkg::PH_IDLE;
    enc_count      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_silence_runs();
    test_byte_patterns();
    test_empty_bursts();
    test_level_extremes();
    test_long_extremes();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    waited = 0;
    while (predicted_outputs.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
